### hdl/cfd_pkg.sv
// types and constants shared by the command frame deframer modules
// no dependencies; imported by cfd_ctrl, cfd_datapath and the top level
`default_nettype none

package cfd_pkg;

    localparam logic [7:0] SYNC_A      = 8'hA5;
    localparam logic [7:0] SYNC_B      = 8'h5A;
    localparam logic [7:0] LOC_PFX0    = 8'h52;
    localparam logic [7:0] LOC_PFX1    = 8'h4C;
    localparam logic [7:0] LOC_PFX2    = 8'h59;
    localparam logic [7:0] CODE_REBOOT = 8'h01;
    localparam logic [7:0] LOC_LEN     = 8'd4;

    typedef enum logic [1:0] {
        KIND_FWD    = 2'd0,
        KIND_REBOOT = 2'd1,
        KIND_CHAN   = 2'd2,
        KIND_IGNORE = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SRCH0,
        ST_SRCH,
        ST_LEN_A,
        ST_LEN_B,
        ST_LEN_C,
        ST_PAY_W,
        ST_PAY,
        ST_CK,
        ST_LOC,
        ST_FWD_W,
        ST_FWD
    } state_t;

    typedef enum logic [2:0] {
        OFF_HOLD,
        OFF_CLR,
        OFF_INC,
        OFF_LEN,
        OFF_PAY
    } off_op_t;

    typedef enum logic [2:0] {
        DROP_NONE,
        DROP_ONE,
        DROP_HIT,
        DROP_MISS,
        DROP_FRAME
    } drop_op_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_LOCAL,
        EMIT_FWD
    } emit_op_t;

    typedef struct packed {
        logic     wr_in;
        off_op_t  off_op;
        drop_op_t drop_op;
        logic     len_load;
        logic     pay_acc;
        logic     prev_load;
        emit_op_t emit_op;
    } cmd_t;

    typedef struct packed {
        logic fill_lt4;
        logic found;
        logic srch_end;
        logic len_bad;
        logic len_short;
        logic pay_end;
        logic ck_ok;
        logic is_local;
        logic fwd_last;
        logic out_free;
    } sts_t;

    // channel table for the set channel codes; bit 8 flags a known code
    function automatic logic [8:0] channel_of(input logic [7:0] code);
        logic [8:0] r;
        case (code)
            8'h10:   r = {1'b1, 8'd84};
            8'h11:   r = {1'b1, 8'd78};
            8'h12:   r = {1'b1, 8'd67};
            8'h13:   r = {1'b1, 8'd50};
            8'h14:   r = {1'b1, 8'd33};
            8'h15:   r = {1'b1, 8'd17};
            8'h16:   r = {1'b1, 8'd2};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/cfd_datapath.sv
// datapath of the command frame deframer: circular byte window, scan offset,
// checksum, local command decode and result register; depends on cfd_pkg
`default_nettype none

module cfd_datapath #(
    parameter int MAX_PAYLOAD  = 16,
    parameter int WINDOW_DEPTH = 20
) (
    input  wire              clk,
    input  wire              rst_n,
    input  cfd_pkg::cmd_t    cmd,
    output cfd_pkg::sts_t    sts,
    input  wire  [7:0]       byte_in,
    output logic             out_valid,
    input  wire              out_ready,
    output logic [1:0]       kind,
    output logic [7:0]       value,
    output logic             last
);
    import cfd_pkg::*;

    localparam int PTR_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int ADD_W = CNT_W + 1;

    logic [7:0]       mem [WINDOW_DEPTH];
    logic [7:0]       rdata_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] off_reg, off_next;
    logic [7:0]       prev_reg;
    logic [7:0]       len_reg;
    logic [7:0]       sum_reg;
    logic [7:0]       code_reg;
    logic [2:0]       match_reg;
    logic             out_valid_reg;
    kind_t            kind_reg;
    logic [7:0]       value_reg;
    logic             last_reg;

    logic [PTR_W-1:0] raddr;
    logic [PTR_W-1:0] waddr;
    logic [CNT_W-1:0] drop_n;
    logic [8:0]       len_need;
    logic [8:0]       off_ext;
    logic [8:0]       len_ext;
    logic [8:0]       chan;
    logic             out_free;

    function automatic logic [PTR_W-1:0] wrap(input logic [ADD_W-1:0] s);
        logic [ADD_W-1:0] r;
        r = s;
        if (s >= ADD_W'(WINDOW_DEPTH))
            r = s - ADD_W'(WINDOW_DEPTH);
        return r[PTR_W-1:0];
    endfunction

    assign raddr    = wrap(ADD_W'(head_reg) + ADD_W'(off_reg));
    assign waddr    = wrap(ADD_W'(head_reg) + ADD_W'(fill_reg));
    assign len_need = {1'b0, rdata_reg} + 9'd4;
    assign off_ext  = 9'(off_reg);
    assign len_ext  = {1'b0, len_reg};
    assign out_free = !out_valid_reg || out_ready;
    assign chan     = channel_of(code_reg);

    assign sts.fill_lt4  = fill_reg < CNT_W'(4);
    assign sts.found     = (off_reg >= CNT_W'(2)) && (prev_reg == SYNC_A)
                           && (rdata_reg == SYNC_B);
    assign sts.srch_end  = off_reg == fill_reg;
    assign sts.len_bad   = (rdata_reg == 8'd0) || (rdata_reg > 8'(MAX_PAYLOAD));
    assign sts.len_short = 9'(fill_reg) < len_need;
    assign sts.pay_end   = off_ext == len_ext + 9'd3;
    assign sts.ck_ok     = rdata_reg == sum_reg;
    assign sts.is_local  = (len_reg == LOC_LEN) && (&match_reg);
    assign sts.fwd_last  = off_ext == len_ext + 9'd2;
    assign sts.out_free  = out_free;

    always_comb
    begin
        case (cmd.drop_op)
            DROP_ONE:   drop_n = CNT_W'(1);
            DROP_HIT:   drop_n = off_reg - CNT_W'(2);
            DROP_MISS:  drop_n = fill_reg - CNT_W'(1);
            DROP_FRAME: drop_n = CNT_W'(len_ext + 9'd4);
            default:    drop_n = '0;
        endcase
    end

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (cmd.wr_in)
        begin
            if (fill_reg == CNT_W'(WINDOW_DEPTH))
                head_next = wrap(ADD_W'(head_reg) + ADD_W'(1));
            else
                fill_next = fill_reg + CNT_W'(1);
        end
        else
        begin
            head_next = wrap(ADD_W'(head_reg) + ADD_W'(drop_n));
            fill_next = fill_reg - drop_n;
        end
    end

    always_comb
    begin
        case (cmd.off_op)
            OFF_CLR: off_next = '0;
            OFF_INC: off_next = off_reg + CNT_W'(1);
            OFF_LEN: off_next = CNT_W'(2);
            OFF_PAY: off_next = CNT_W'(3);
            default: off_next = off_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_in)
            mem[waddr] <= byte_in;
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            fill_reg      <= '0;
            off_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
            off_reg  <= off_next;
            if (cmd.emit_op != EMIT_NONE)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prev_load)
            prev_reg <= rdata_reg;
        if (cmd.len_load)
        begin
            len_reg   <= rdata_reg;
            sum_reg   <= rdata_reg ^ SYNC_A ^ SYNC_B;
            match_reg <= '0;
        end
        if (cmd.pay_acc)
        begin
            sum_reg <= sum_reg ^ rdata_reg;
            if (off_reg == CNT_W'(4))
                match_reg[0] <= rdata_reg == LOC_PFX0;
            if (off_reg == CNT_W'(5))
                match_reg[1] <= rdata_reg == LOC_PFX1;
            if (off_reg == CNT_W'(6))
                match_reg[2] <= rdata_reg == LOC_PFX2;
            if (off_reg == CNT_W'(7))
                code_reg <= rdata_reg;
        end
        case (cmd.emit_op)
            EMIT_LOCAL:
            begin
                last_reg <= 1'b1;
                if (code_reg == CODE_REBOOT)
                begin
                    kind_reg  <= KIND_REBOOT;
                    value_reg <= 8'd0;
                end
                else if (chan[8])
                begin
                    kind_reg  <= KIND_CHAN;
                    value_reg <= chan[7:0];
                end
                else
                begin
                    kind_reg  <= KIND_IGNORE;
                    value_reg <= 8'd0;
                end
            end
            EMIT_FWD:
            begin
                kind_reg  <= KIND_FWD;
                value_reg <= rdata_reg;
                last_reg  <= sts.fwd_last;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign value     = value_reg;
    assign last      = last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("window fill beyond depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg < PTR_W'(WINDOW_DEPTH))
        else $error("window head out of range");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_op != EMIT_NONE |-> out_free)
        else $error("result loaded over a pending request");

    a_write_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_in |=> fill_reg != '0)
        else $error("window empty after a byte write");

endmodule

`default_nettype wire

### hdl/cfd_ctrl.sv
// controller of the command frame deframer: sync hunt, length, checksum and
// result sequencing over the datapath window; depends on cfd_pkg
`default_nettype none

module cfd_ctrl (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           in_valid,
    output logic          in_ready,
    output cfd_pkg::cmd_t cmd,
    input  cfd_pkg::sts_t sts
);
    import cfd_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.wr_in     = 1'b0;
        cmd.off_op    = OFF_HOLD;
        cmd.drop_op   = DROP_NONE;
        cmd.len_load  = 1'b0;
        cmd.pay_acc   = 1'b0;
        cmd.prev_load = 1'b0;
        cmd.emit_op   = EMIT_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.wr_in  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.fill_lt4)
                    state_next = ST_IDLE;
                else
                begin
                    cmd.off_op = OFF_CLR;
                    state_next = ST_SRCH0;
                end
            end
            ST_SRCH0:
            begin
                cmd.off_op = OFF_INC;
                state_next = ST_SRCH;
            end
            ST_SRCH:
            begin
                cmd.prev_load = 1'b1;
                if (sts.found)
                begin
                    cmd.drop_op = DROP_HIT;
                    state_next  = ST_LEN_A;
                end
                else if (sts.srch_end)
                begin
                    cmd.drop_op = DROP_MISS;
                    state_next  = ST_IDLE;
                end
                else
                    cmd.off_op = OFF_INC;
            end
            ST_LEN_A:
            begin
                if (sts.fill_lt4)
                    state_next = ST_IDLE;
                else
                begin
                    cmd.off_op = OFF_LEN;
                    state_next = ST_LEN_B;
                end
            end
            ST_LEN_B:
            begin
                state_next = ST_LEN_C;
            end
            ST_LEN_C:
            begin
                cmd.len_load = 1'b1;
                if (sts.len_bad)
                begin
                    cmd.drop_op = DROP_ONE;
                    state_next  = ST_CHECK;
                end
                else if (sts.len_short)
                    state_next = ST_IDLE;
                else
                begin
                    cmd.off_op = OFF_PAY;
                    state_next = ST_PAY_W;
                end
            end
            ST_PAY_W:
            begin
                cmd.off_op = OFF_INC;
                state_next = ST_PAY;
            end
            ST_PAY:
            begin
                cmd.pay_acc = 1'b1;
                if (sts.pay_end)
                    state_next = ST_CK;
                else
                    cmd.off_op = OFF_INC;
            end
            ST_CK:
            begin
                if (!sts.ck_ok)
                begin
                    cmd.drop_op = DROP_ONE;
                    state_next  = ST_CHECK;
                end
                else if (sts.is_local)
                    state_next = ST_LOC;
                else
                begin
                    cmd.off_op = OFF_PAY;
                    state_next = ST_FWD_W;
                end
            end
            ST_LOC:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_op = EMIT_LOCAL;
                    cmd.drop_op = DROP_FRAME;
                    state_next  = ST_CHECK;
                end
            end
            ST_FWD_W:
            begin
                state_next = ST_FWD;
            end
            ST_FWD:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_op = EMIT_FWD;
                    if (sts.fwd_last)
                    begin
                        cmd.drop_op = DROP_FRAME;
                        state_next  = ST_CHECK;
                    end
                    else
                    begin
                        cmd.off_op = OFF_INC;
                        state_next = ST_FWD_W;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_CHECK)
        else $error("accepted byte not followed by a window check");

    a_pay_stay: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PAY && !sts.pay_end |=> state_reg == ST_PAY)
        else $error("payload pass left before its end");

    a_fwd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FWD && !sts.out_free |=> state_reg == ST_FWD)
        else $error("forwarding moved on while the result slot was full");

endmodule

`default_nettype wire

### hdl/command_frame_deframer_unit.sv
// Command frame deframer. One host byte is taken per request into a circular
// window of WINDOW_DEPTH bytes; the window is hunted for A5 5A, a length of
// 1..MAX_PAYLOAD, the payload and an XOR checksum, and each good frame gives
// one local command result or its payload bytes with last set on the final
// one. Bad length or checksum drops one byte and the window is rescanned.
// After each byte is taken, the window is walked through the single read port
// of the window memory: a window check, the sync hunt, the length, the
// checksum pass, then a local command result or each forwarded byte; no
// further byte is taken until the walk ends, and every bad length or checksum
// adds another check and hunt. A pending result does not hold off the next
// byte, but a further result of the same scan waits until the pending one is
// taken. Top level; depends on cfd_pkg, cfd_ctrl and cfd_datapath.
`default_nettype none

module command_frame_deframer_unit #(
    parameter int MAX_PAYLOAD  = 16,
    parameter int WINDOW_DEPTH = 20
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_ready,
    input  wire  [7:0] byte_in,
    output logic       out_valid,
    input  wire        out_ready,
    output logic [1:0] kind,
    output logic [7:0] value,
    output logic       last
);
    import cfd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    cfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    cfd_datapath #(
        .MAX_PAYLOAD  (MAX_PAYLOAD),
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .byte_in   (byte_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .value     (value),
        .last      (last)
    );

endmodule

`default_nettype wire

### sim/testbench.sv
// self-checking testbench for command_frame_deframer_unit: host bytes in, deframed results out
// holds its own window-based frame predictor; depends on cfd_pkg and the unit's rtl only
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cfd_pkg::*;

    localparam int MAX_PAYLOAD       = 16;
    localparam int WINDOW_DEPTH      = 20;
    localparam int RANDOM_BYTES      = 80;
    localparam int WATCHDOG_LIMIT    = 5000;
    localparam int RX_HOLD_CYCLES    = 600;
    localparam int DRAIN_CYCLES      = 100;
    localparam logic [7:0] CHAN_CODE_FIRST = 8'h10;
    localparam logic [7:0] CHAN_CODE_LAST  = 8'h16;
    localparam logic [7:0] CHANNEL_NUMBER [7] = '{8'd84, 8'd78, 8'd67, 8'd50, 8'd33, 8'd17, 8'd2};

    typedef logic [7:0] byte_q_t [$];

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic       last;
    } deframed_result_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] byte_in   = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;

    byte_q_t          host_bytes;
    byte_q_t          host_window;
    deframed_result_t pending_results [$];

    int unsigned total_bytes  = 0;
    int unsigned bytes_taken  = 0;
    int unsigned error_count  = 0;
    int unsigned send_gap     = 0;
    int unsigned send_calm    = 0;
    int unsigned recv_gap     = 0;
    int unsigned recv_calm    = 0;
    int unsigned hold_left    = 0;
    bit          hold_done    = 1'b0;
    int unsigned quiet_cycles = 0;

    command_frame_deframer_unit #(
        .MAX_PAYLOAD  (MAX_PAYLOAD),
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .byte_in   (byte_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .value     (value),
        .last      (last)
    );

    always #2 clk = ~clk;

    // mostly short gaps, a few long ones, and now and then a calm stretch with none
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            calm = $urandom_range(20, 60);
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic void add_result(input kind_t k, input logic [7:0] v, input logic l);
        deframed_result_t r;
        r.kind  = k;
        r.value = v;
        r.last  = l;
        pending_results.push_back(r);
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        int unsigned s;
        int unsigned len;
        logic [7:0]  sum;
        logic [7:0]  code;
        if (host_window.size() >= WINDOW_DEPTH)
            repeat (host_window.size() - WINDOW_DEPTH + 1)
                void'(host_window.pop_front());
        host_window.push_back(b);
        while (host_window.size() >= 4)
        begin
            s = 0;
            while (s + 1 < host_window.size() &&
                   !(host_window[s] == SYNC_A && host_window[s + 1] == SYNC_B))
                s++;
            repeat (s)
                void'(host_window.pop_front());
            if (host_window.size() < 4)
                break;
            len = host_window[2];
            if (len == 0 || len > MAX_PAYLOAD)
            begin
                void'(host_window.pop_front());
                continue;
            end
            if (host_window.size() < len + 4)
                break;
            sum = 8'(len) ^ SYNC_A ^ SYNC_B;
            for (int i = 0; i < len; i++)
                sum ^= host_window[3 + i];
            if (host_window[3 + len] != sum)
            begin
                void'(host_window.pop_front());
                continue;
            end
            if (len == LOC_LEN && host_window[3] == LOC_PFX0 &&
                host_window[4] == LOC_PFX1 && host_window[5] == LOC_PFX2)
            begin
                code = host_window[6];
                if (code == CODE_REBOOT)
                    add_result(KIND_REBOOT, 8'h00, 1'b1);
                else if (code >= CHAN_CODE_FIRST && code <= CHAN_CODE_LAST)
                    add_result(KIND_CHAN, CHANNEL_NUMBER[code - CHAN_CODE_FIRST], 1'b1);
                else
                    add_result(KIND_IGNORE, 8'h00, 1'b1);
            end
            else
            begin
                for (int i = 0; i < len; i++)
                    add_result(KIND_FWD, host_window[3 + i], (i + 1 == len));
            end
            repeat (len + 4)
                void'(host_window.pop_front());
        end
    endfunction

    function automatic byte_q_t framed(input byte_q_t pl, input bit bad_ck);
        byte_q_t    f;
        logic [7:0] ck;
        ck = SYNC_A ^ SYNC_B ^ 8'(pl.size());
        f.push_back(SYNC_A);
        f.push_back(SYNC_B);
        f.push_back(8'(pl.size()));
        foreach (pl[i])
        begin
            ck ^= pl[i];
            f.push_back(pl[i]);
        end
        if (bad_ck)
            ck ^= 8'($urandom_range(1, 255));
        f.push_back(ck);
        return f;
    endfunction

    // payload bytes lean toward sync values so false syncs turn up inside frames
    function automatic byte_q_t random_payload(input int unsigned n);
        byte_q_t pl;
        repeat (n)
        begin
            case ($urandom_range(0, 15))
                0:       pl.push_back(SYNC_A);
                1:       pl.push_back(SYNC_B);
                default: pl.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        return pl;
    endfunction

    function automatic byte_q_t local_cmd(input logic [7:0] code);
        byte_q_t pl;
        pl.push_back(LOC_PFX0);
        pl.push_back(LOC_PFX1);
        pl.push_back(LOC_PFX2);
        pl.push_back(code);
        return pl;
    endfunction

    function automatic void queue_bytes(input byte_q_t b);
        foreach (b[i])
            host_bytes.push_back(b[i]);
    endfunction

    // outer frame with a bad checksum that wraps a good inner frame
    function automatic void queue_nested(input int unsigned inner_len, input int unsigned pad);
        byte_q_t outer;
        outer = framed(random_payload(inner_len), 1'b0);
        repeat (pad)
            outer.push_back(8'($urandom_range(0, 255)));
        queue_bytes(framed(outer, 1'b1));
    endfunction

    always @(posedge clk)
    begin : drive
        bit took;
        if (rst_n)
        begin
            took = in_valid && in_ready;
            if (took)
            begin
                deframe_byte(byte_in);
                bytes_taken++;
            end
            if (in_valid && !took)
                ;
            else if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (host_bytes.size() > 0)
            begin
                byte_in  <= host_bytes.pop_front();
                in_valid <= 1'b1;
                send_gap = pick_gap(send_calm);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : collect
        deframed_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result kind %0d value %0h last %0b",
                             $time, kind, value, last);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (kind !== want.kind)
                    begin
                        $display("%0t: kind mismatch expected %0d actual %0d",
                                 $time, want.kind, kind);
                        error_count++;
                    end
                    if (value !== want.value)
                    begin
                        $display("%0t: value mismatch expected %0h actual %0h",
                                 $time, want.value, value);
                        error_count++;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t: last mismatch expected %0b actual %0b",
                                 $time, want.last, last);
                        error_count++;
                    end
                end
            end
            // one long receiver hold-off so the unit backs up into its input
            if (!hold_done && bytes_taken >= total_bytes / 2)
            begin
                hold_done = 1'b1;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    recv_gap = pick_gap(recv_calm);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        byte_q_t     pl;
        byte_q_t     f;
        int unsigned directed_bytes;
        int unsigned r;
        int unsigned len;
        logic [7:0]  code;

        // no sync at all, byte extremes
        host_bytes.push_back(8'h00);
        host_bytes.push_back(8'hFF);
        host_bytes.push_back(8'h12);
        // junk before sync, then reboot
        host_bytes.push_back(SYNC_A);
        queue_bytes(framed(local_cmd(CODE_REBOOT), 1'b0));
        // every channel code
        for (int c = CHAN_CODE_FIRST; c <= CHAN_CODE_LAST; c++)
            queue_bytes(framed(local_cmd(8'(c)), 1'b0));
        // unknown local codes around the table and at the extremes
        queue_bytes(framed(local_cmd(CHAN_CODE_FIRST - 8'd1), 1'b0));
        queue_bytes(framed(local_cmd(CHAN_CODE_LAST + 8'd1), 1'b0));
        queue_bytes(framed(local_cmd(8'h00), 1'b0));
        queue_bytes(framed(local_cmd(8'hFF), 1'b0));
        // shortest and longest forwarded payloads
        pl = {};
        pl.push_back(8'h00);
        queue_bytes(framed(pl, 1'b0));
        pl = {};
        for (int i = 0; i < MAX_PAYLOAD; i++)
            pl.push_back(8'hFF ^ 8'(i * 17));
        queue_bytes(framed(pl, 1'b0));
        // near-miss local commands are forwarded
        pl = local_cmd(CODE_REBOOT);
        pl[2] = LOC_PFX2 ^ 8'h01;
        queue_bytes(framed(pl, 1'b0));
        pl = local_cmd(CODE_REBOOT);
        pl.push_back(8'h00);
        queue_bytes(framed(pl, 1'b0));
        pl = local_cmd(CODE_REBOOT);
        void'(pl.pop_back());
        queue_bytes(framed(pl, 1'b0));
        // bad lengths, zero and one past the maximum
        host_bytes.push_back(SYNC_A);
        host_bytes.push_back(SYNC_B);
        host_bytes.push_back(8'h00);
        queue_bytes(framed(local_cmd(CHAN_CODE_FIRST), 1'b0));
        host_bytes.push_back(SYNC_A);
        host_bytes.push_back(SYNC_B);
        host_bytes.push_back(8'(MAX_PAYLOAD + 1));
        queue_bytes(framed(random_payload(3), 1'b0));
        // bad checksum followed by a good frame
        queue_bytes(framed(local_cmd(CODE_REBOOT), 1'b1));
        queue_bytes(framed(random_payload(2), 1'b0));
        // a good frame found on rescan inside a rejected one
        queue_nested(1, 3);
        // incomplete frame, completed later by following bytes
        f = framed(random_payload(5), 1'b0);
        queue_bytes(f[0:3]);
        queue_bytes(f[4:$]);
        directed_bytes = host_bytes.size();

        while (host_bytes.size() < directed_bytes + RANDOM_BYTES)
        begin
            r = $urandom_range(0, 99);
            len = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 6)
                                              : $urandom_range(7, MAX_PAYLOAD);
            if (r < 45)
                queue_bytes(framed(random_payload(len), 1'b0));
            else if (r < 60)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: code = CHAN_CODE_FIRST + 8'($urandom_range(0, 6));
                    5, 6:          code = CODE_REBOOT;
                    default:       code = 8'($urandom_range(0, 255));
                endcase
                queue_bytes(framed(local_cmd(code), $urandom_range(0, 9) == 0));
            end
            else if (r < 70)
                queue_bytes(framed(random_payload(len), 1'b1));
            else if (r < 78)
            begin
                host_bytes.push_back(SYNC_A);
                host_bytes.push_back(SYNC_B);
                host_bytes.push_back($urandom_range(0, 3) == 0 ? 8'h00
                    : 8'($urandom_range(MAX_PAYLOAD + 1, 255)));
                queue_bytes(random_payload($urandom_range(0, 3)));
            end
            else if (r < 88)
                queue_bytes(random_payload($urandom_range(1, 4)));
            else if (r < 94)
            begin
                f = framed(random_payload(len), 1'b0);
                queue_bytes(f[0:$urandom_range(0, f.size() - 2)]);
            end
            else
                queue_nested($urandom_range(1, 4), $urandom_range(0, 3));
        end
        total_bytes = host_bytes.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        wait (bytes_taken == total_bytes);
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

### command_frame_deframer_unit.f
hdl/cfd_pkg.sv
hdl/cfd_datapath.sv
hdl/cfd_ctrl.sv
hdl/command_frame_deframer_unit.sv
sim/testbench.sv
